@@ hw/rtl/tcre_pkg.sv @@
// Shared types and constants for the triple coprime ratio estimator.
// No dependencies; imported by the output interface, controller, datapath and top level.
package tcre_pkg;

  localparam int unsigned OUT_COUNT_BITS = 32;
  localparam int unsigned RATIO_BITS     = 48;

  // result item as held in the output register
  typedef struct packed {
    logic                      is_coprime;
    logic [OUT_COUNT_BITS-1:0] coprime_total;
    logic [OUT_COUNT_BITS-1:0] triple_total;
    logic [RATIO_BITS-1:0]     ratio_estimate;
    logic                      ratio_valid;
  } tcre_res_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load_in;    // capture triple, start first gcd
    logic gcd_step;   // one binary gcd step
    logic gcd_next;   // start second gcd with third value
    logic cnt_upd;    // update counters from final gcd
    logic div_load;   // start ratio division
    logic div_step;   // one restoring division step
    logic out_load;   // move result into output register
  } tcre_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic gcd_done;
    logic div_last;
    logic cnt_nonzero;
  } tcre_sts_t;

endpackage

@@ hw/rtl/tcre_in_if.sv @@
// Input channel interface: valid/ready handshake carrying one triple.
// Depends on nothing but the VALUE_BITS parameter.
interface tcre_in_if #(
  parameter int unsigned VALUE_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] first_value;
  logic [VALUE_BITS-1:0] second_value;
  logic [VALUE_BITS-1:0] third_value;

  modport source (output valid, first_value, second_value, third_value, input ready);
  modport sink   (input valid, first_value, second_value, third_value, output ready);
endinterface

@@ hw/rtl/tcre_out_if.sv @@
// Result channel interface: valid/ready handshake carrying flag, counts and ratio.
// Field widths come from tcre_pkg.
interface tcre_out_if
  import tcre_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      is_coprime;
  logic [OUT_COUNT_BITS-1:0] coprime_total;
  logic [OUT_COUNT_BITS-1:0] triple_total;
  logic [RATIO_BITS-1:0]     ratio_estimate;
  logic                      ratio_valid;

  modport source (output valid, is_coprime, coprime_total, triple_total, ratio_estimate,
                  ratio_valid, input ready);
  modport sink   (input valid, is_coprime, coprime_total, triple_total, ratio_estimate,
                  ratio_valid, output ready);
endinterface

@@ hw/rtl/tcre_ctrl.sv @@
// Controller state machine: sequences gcd, counter update, division and output load.
// Depends on tcre_pkg for the command and status structs.
module tcre_ctrl
  import tcre_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_free,
  input  tcre_sts_t sts,
  output tcre_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD1 = 3'd1;
  localparam logic [2:0] S_GCD2 = 3'd2;
  localparam logic [2:0] S_CNT  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_GCD1;
        end
      end
      S_GCD1: begin
        if (sts.gcd_done) begin
          cmd.gcd_next = 1'b1;
          state_nxt    = S_GCD2;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_GCD2: begin
        if (sts.gcd_done) begin
          cmd.cnt_upd = 1'b1;
          state_nxt   = S_CNT;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_CNT: begin
        // no division while the coprime count is still zero
        if (sts.cnt_nonzero) begin
          cmd.div_load = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/tcre_dp.sv @@
// Datapath: binary gcd unit, saturating counters and restoring divider.
// Depends on tcre_pkg; driven by commands from tcre_ctrl.
module tcre_dp
  import tcre_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 31,
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcre_cmd_t             cmd,
  input  logic [VALUE_BITS-1:0] first_value,
  input  logic [VALUE_BITS-1:0] second_value,
  input  logic [VALUE_BITS-1:0] third_value,
  output tcre_sts_t             sts,
  output tcre_res_t             res
);

  localparam int unsigned KW    = $clog2(VALUE_BITS + 1);
  localparam int unsigned NBITS = COUNT_BITS + FRAC_BITS;
  localparam int unsigned DW    = $clog2(NBITS);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // gcd unit
  logic [VALUE_BITS-1:0] u_r, u_nxt;
  logic [VALUE_BITS-1:0] v_r, v_nxt;
  logic [KW-1:0]         k_r, k_nxt;
  logic [VALUE_BITS-1:0] c_r;
  logic [VALUE_BITS-1:0] gcd_val;
  logic                  gcd_done;

  // counters
  logic [COUNT_BITS-1:0] cop_cnt_r;
  logic [COUNT_BITS-1:0] all_cnt_r;
  logic                  cop_r;

  // divider
  logic [NBITS-1:0]      num_r;
  logic [COUNT_BITS-1:0] rem_r;
  logic [RATIO_BITS-1:0] quo_r;
  logic                  over_r;
  logic [DW-1:0]         dcnt_r;
  logic [COUNT_BITS:0]   rem_sh;
  logic                  rem_ge;

  assign gcd_done = (u_r == '0) || (v_r == '0);
  // one operand is zero here, so the OR picks the other
  assign gcd_val  = VALUE_BITS'((u_r | v_r) << k_r);

  always_comb begin
    u_nxt = u_r;
    v_nxt = v_r;
    k_nxt = k_r;
    priority if (!u_r[0] && !v_r[0]) begin
      u_nxt = u_r >> 1;
      v_nxt = v_r >> 1;
      k_nxt = k_r + KW'(1);
    end else if (!u_r[0]) begin
      u_nxt = u_r >> 1;
    end else if (!v_r[0]) begin
      v_nxt = v_r >> 1;
    end else if (u_r >= v_r) begin
      u_nxt = (u_r - v_r) >> 1;
    end else begin
      v_nxt = (v_r - u_r) >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      u_r <= first_value;
      v_r <= second_value;
      c_r <= third_value;
      k_r <= '0;
    end else if (cmd.gcd_next) begin
      u_r <= gcd_val;
      v_r <= c_r;
      k_r <= '0;
    end else if (cmd.gcd_step && !gcd_done) begin
      u_r <= u_nxt;
      v_r <= v_nxt;
      k_r <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cop_cnt_r <= '0;
      all_cnt_r <= '0;
      cop_r     <= 1'b0;
    end else if (cmd.cnt_upd) begin
      cop_r <= (gcd_val == VALUE_BITS'(1));
      if ((gcd_val == VALUE_BITS'(1)) && (cop_cnt_r != CNT_MAX)) begin
        cop_cnt_r <= cop_cnt_r + COUNT_BITS'(1);
      end
      if (all_cnt_r != CNT_MAX) begin
        all_cnt_r <= all_cnt_r + COUNT_BITS'(1);
      end
    end
  end

  assign rem_sh = {rem_r, num_r[NBITS-1]};
  assign rem_ge = (rem_sh >= {1'b0, cop_cnt_r});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      num_r  <= {all_cnt_r, {FRAC_BITS{1'b0}}};
      rem_r  <= '0;
      quo_r  <= '0;
      over_r <= 1'b0;
      dcnt_r <= DW'(NBITS - 1);
    end else if (cmd.div_step) begin
      num_r <= num_r << 1;
      // a set top bit would be shifted out: quotient exceeds the ratio field
      if (quo_r[RATIO_BITS-1]) begin
        over_r <= 1'b1;
      end
      quo_r <= {quo_r[RATIO_BITS-2:0], rem_ge};
      if (rem_ge) begin
        rem_r <= COUNT_BITS'(rem_sh - {1'b0, cop_cnt_r});
      end else begin
        rem_r <= rem_sh[COUNT_BITS-1:0];
      end
      dcnt_r <= dcnt_r - DW'(1);
    end
  end

  assign sts.gcd_done    = gcd_done;
  assign sts.div_last    = (dcnt_r == '0);
  assign sts.cnt_nonzero = (cop_cnt_r != '0);

  always_comb begin
    res.is_coprime     = cop_r;
    res.coprime_total  = OUT_COUNT_BITS'(cop_cnt_r);
    res.triple_total   = OUT_COUNT_BITS'(all_cnt_r);
    res.ratio_valid    = (cop_cnt_r != '0);
    res.ratio_estimate = '0;
    if (cop_cnt_r != '0) begin
      res.ratio_estimate = over_r ? {RATIO_BITS{1'b1}} : quo_r;
    end
  end

endmodule

@@ hw/rtl/triple_coprime_ratio_estimator_core.sv @@
// Top level of the triple coprime ratio estimator: controller, datapath, output register.
// Depends on tcre_pkg, tcre_in_if, tcre_out_if, tcre_ctrl and tcre_dp.

// Takes one triple at a time: in_chan.ready is high only while the block is idle.
// Each triple runs two binary gcds on a shared subtract/shift unit (one step per
// cycle, at most about 2*VALUE_BITS steps each), a counter update, then a
// restoring divider at one quotient bit per cycle for COUNT_BITS+FRAC_BITS bits
// (skipped while no coprime triple has been seen), and finally loads the output
// register, waiting there while it still holds an untaken result. The output
// register lets the next triple start while a result waits to be taken; counters
// saturate at 2^COUNT_BITS-1 and the ratio at 2^48-1.
module triple_coprime_ratio_estimator_core
  import tcre_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 31,
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input logic        clk,
  input logic        rst_n,
  tcre_in_if.sink    in_chan,
  tcre_out_if.source out_chan
);

  tcre_cmd_t cmd;
  tcre_sts_t sts;
  tcre_res_t res;
  tcre_res_t out_data_r;
  logic      out_valid_r;
  logic      out_free;

  assign out_free = !out_valid_r || out_chan.ready;

  tcre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcre_dp #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .first_value  (in_chan.first_value),
    .second_value (in_chan.second_value),
    .third_value  (in_chan.third_value),
    .sts          (sts),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= res;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.is_coprime     = out_data_r.is_coprime;
  assign out_chan.coprime_total  = out_data_r.coprime_total;
  assign out_chan.triple_total   = out_data_r.triple_total;
  assign out_chan.ratio_estimate = out_data_r.ratio_estimate;
  assign out_chan.ratio_valid    = out_data_r.ratio_valid;

endmodule
